### rtl/wsp_pkg.sv
// wsp_pkg: shared types and constants of the wheel sync pid drive block
// no dependencies; every other file but wsp_queue refers to it by scoped names
package wsp_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BASE_PWM    = 2'd0,
    REG_START_DIST  = 2'd1,
    REG_FINISH_DIST = 2'd2,
    REG_INT_PERIOD  = 2'd3
  } wsp_reg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam int SONAR_W  = 16;
  localparam int PWM_W    = 8;
  localparam int START_W  = 8;
  localparam int TARGET_W = 23;
  localparam int PERIOD_W = 4;
  localparam int DRIVE_W  = 28;
  localparam int SUM_W    = 32;

  // reset values of the configuration registers
  localparam logic signed [PWM_W-1:0] BASE_PWM_RST    = 8'sd0;
  localparam logic [START_W-1:0]      START_DIST_RST  = 8'd5;
  localparam logic [TARGET_W-1:0]     FINISH_DIST_RST = 23'd2800;
  localparam logic [PERIOD_W-1:0]     INT_PERIOD_RST  = 4'd10;

  // run distance scale 0.87266 as signed q1.16
  localparam int DIST_SHIFT = 16;
  localparam logic signed [DIST_SHIFT:0] DIST_SCALE = 17'sd57190;

  // divide by 20: drop two bits, then multiply by ceil(2^34/5) and keep bits from 34 up
  localparam int DIV_IN_W  = SUM_W - 2;
  localparam int DIV_K_W   = 32;
  localparam logic [DIV_K_W-1:0] DIV5_RECIP = 32'hCCCC_CCCD;
  localparam int DIV_SHIFT = 34;
  localparam int IMAG_W    = 28;

  // depth of the queue between front and back
  localparam int QDEPTH = 4;

  // per-beat classification carried from front to back
  typedef struct packed {
    logic run;   // latch armed and no arming reading: pid runs
    logic fin;   // run distance reached the target
  } wsp_ctl_t;

  // configuration register file contents
  typedef struct packed {
    logic signed [PWM_W-1:0] base_pwm;
    logic [START_W-1:0]      start_distance;
    logic [TARGET_W-1:0]     finish_dist;
    logic [PERIOD_W-1:0]     integral_period;
  } wsp_cfg_t;

endpackage

### rtl/wsp_ifs.sv
// wsp_ifs: valid/ready channel interfaces of the wheel sync pid drive block
// depends on wsp_pkg for field widths
interface wsp_in_if #(parameter int COUNT_BITS = 24);
  logic                                valid;
  logic                                ready;
  logic signed [wsp_pkg::SONAR_W-1:0]  sonar_distance;
  logic signed [COUNT_BITS-1:0]        left_count;
  logic signed [COUNT_BITS-1:0]        right_count;

  modport source (output valid, output sonar_distance, output left_count,
                  output right_count, input ready);
  modport sink   (input valid, input sonar_distance, input left_count,
                  input right_count, output ready);
endinterface

interface wsp_out_if;
  logic                                valid;
  logic                                ready;
  logic                                drive_valid;
  logic signed [wsp_pkg::DRIVE_W-1:0]  left_drive;
  logic signed [wsp_pkg::DRIVE_W-1:0]  right_drive;
  logic                                finished;

  modport source (output valid, output drive_valid, output left_drive,
                  output right_drive, output finished, input ready);
  modport sink   (input valid, input drive_valid, input left_drive,
                  input right_drive, input finished, output ready);
endinterface

interface wsp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [wsp_pkg::CFG_IDX_W-1:0]      index;
  logic [wsp_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/wheel_sync_pid_drive.sv
// Wheel sync PID drive. Takes one beat per cycle while not stalled (sonar distance, left and
// right encoder counts) and returns exactly one result beat for each, in order. A sonar reading
// from 0 to start_distance-1 arms a sticky start latch; once armed, a PID on right minus left
// count steers base_pwm +/- turn, saturated to 28 bits, until the scaled average count reaches
// the finish distance, when finished is reported instead. Sustained rate is one beat per clock
// while the result channel is ready. The path runs through two front stages (classify, distance
// multiply), the four-entry queue and four back stages (sum update, divide-by-20 multiply, turn,
// drive saturation). The sum and counter update in the first back stage is the only loop besides
// the start latch. Configuration writes are always accepted and must only be made while no beat
// is in flight.
// depends on wsp_pkg, wsp_ifs, wsp_front, wsp_queue, wsp_back
module wheel_sync_pid_drive #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  wsp_in_if.sink      in_bus,
  wsp_out_if.source   out_bus,
  wsp_cfg_if.sink     cfg_bus
);

  localparam int DW = COUNT_BITS + 1;
  localparam int QW = $bits(wsp_pkg::wsp_ctl_t) + DW;

  wsp_pkg::wsp_cfg_t    cfg_r;
  logic                 q_push, q_full, q_pop, q_valid;
  wsp_pkg::wsp_ctl_t    push_ctl, pop_ctl;
  logic signed [DW-1:0] push_diff, pop_diff;
  logic [QW-1:0]        pop_data;

  // configuration registers
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_pwm        <= wsp_pkg::BASE_PWM_RST;
      cfg_r.start_distance  <= wsp_pkg::START_DIST_RST;
      cfg_r.finish_dist     <= wsp_pkg::FINISH_DIST_RST;
      cfg_r.integral_period <= wsp_pkg::INT_PERIOD_RST;
    end else if (cfg_bus.valid) begin
      case (wsp_pkg::wsp_reg_t'(cfg_bus.index))
        wsp_pkg::REG_BASE_PWM: begin
          cfg_r.base_pwm <= signed'(cfg_bus.data[wsp_pkg::PWM_W-1:0]);
        end
        wsp_pkg::REG_START_DIST: begin
          cfg_r.start_distance <= cfg_bus.data[wsp_pkg::START_W-1:0];
        end
        wsp_pkg::REG_FINISH_DIST: begin
          cfg_r.finish_dist <= cfg_bus.data[wsp_pkg::TARGET_W-1:0];
        end
        wsp_pkg::REG_INT_PERIOD: begin
          cfg_r.integral_period <= cfg_bus.data[wsp_pkg::PERIOD_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // front: latch, classification, finish flag
  wsp_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_bus.valid),
    .in_ready          (in_bus.ready),
    .in_sonar_distance (in_bus.sonar_distance),
    .in_left_count     (in_bus.left_count),
    .in_right_count    (in_bus.right_count),
    .cfg               (cfg_r),
    .q_push            (q_push),
    .q_ctl             (push_ctl),
    .q_diff            (push_diff),
    .q_full            (q_full)
  );

  // queue between front and back
  wsp_queue #(.WIDTH(QW), .DEPTH(wsp_pkg::QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_ctl, push_diff}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  assign pop_ctl  = wsp_pkg::wsp_ctl_t'(pop_data[QW-1:DW]);
  assign pop_diff = signed'(pop_data[DW-1:0]);

  // back: pid state and drives
  wsp_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_ctl           (pop_ctl),
    .q_diff          (pop_diff),
    .q_pop           (q_pop),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_drive_valid (out_bus.drive_valid),
    .out_left_drive  (out_bus.left_drive),
    .out_right_drive (out_bus.right_drive),
    .out_finished    (out_bus.finished)
  );

endmodule

### rtl/wsp_front.sv
// wsp_front: accepts input beats, keeps the start latch, classifies each beat
// and works out the wheel difference and the finish flag; depends on wsp_pkg
module wsp_front #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [wsp_pkg::SONAR_W-1:0]  in_sonar_distance,
  input  logic signed [COUNT_BITS-1:0]        in_left_count,
  input  logic signed [COUNT_BITS-1:0]        in_right_count,
  input  wsp_pkg::wsp_cfg_t                   cfg,
  output logic                                q_push,
  output wsp_pkg::wsp_ctl_t                   q_ctl,
  output logic signed [COUNT_BITS:0]          q_diff,
  input  logic                                q_full
);

  localparam int DW = COUNT_BITS + 1;
  localparam int PW = COUNT_BITS + wsp_pkg::DIST_SHIFT;
  localparam int RW = ((COUNT_BITS > wsp_pkg::TARGET_W) ? COUNT_BITS
                                                        : wsp_pkg::TARGET_W) + 1;

  logic                         start_latch_r;
  logic                         f1_v_r, f1_run_r;
  logic signed [DW-1:0]         f1_diff_r;
  logic signed [COUNT_BITS-1:0] f1_avg_r;
  logic                         f2_v_r, f2_run_r;
  logic signed [DW-1:0]         f2_diff_r;
  logic signed [PW-1:0]         f2_prod_r;

  logic                         accept, arm, f1_en, f2_en;
  logic [wsp_pkg::SONAR_W-2:0]  start_x;
  logic signed [DW-1:0]         diff, lr_sum, lr_adj;
  logic signed [PW-1:0]         prod, prod_adj;
  logic signed [COUNT_BITS-1:0] travel_dist;
  logic signed [RW-1:0]         run_x, target_x;

  // stage enables, stalling back from the queue
  assign f2_en    = !f2_v_r || !q_full;
  assign f1_en    = !f1_v_r || f2_en;
  assign in_ready = f1_en;
  assign accept   = in_valid && in_ready;

  // a non-negative reading below start_distance arms the latch
  assign start_x = (wsp_pkg::SONAR_W-1)'(cfg.start_distance);
  assign arm     = !in_sonar_distance[wsp_pkg::SONAR_W-1] &&
                   (in_sonar_distance[wsp_pkg::SONAR_W-2:0] < start_x);

  // difference and average of the counts, average rounds toward zero
  assign diff   = DW'(in_right_count) - DW'(in_left_count);
  assign lr_sum = DW'(in_left_count) + DW'(in_right_count);
  assign lr_adj = lr_sum + DW'(lr_sum[DW-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_latch_r <= 1'b0;
    end else if (accept && arm) begin
      start_latch_r <= 1'b1;
    end
  end

  // stage 1: classified beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (f1_en) begin
      f1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_en) begin
      f1_run_r  <= start_latch_r && !arm;
      f1_diff_r <= diff;
      f1_avg_r  <= lr_adj[DW-1:1];
    end
  end

  // stage 2: scaled run distance product
  assign prod = f1_avg_r * wsp_pkg::DIST_SCALE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (f2_en) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_en) begin
      f2_run_r  <= f1_run_r;
      f2_diff_r <= f1_diff_r;
      f2_prod_r <= prod;
    end
  end

  // run distance rounds toward zero, then compare against the target
  assign prod_adj = f2_prod_r + (f2_prod_r[PW-1] ? PW'((1 << wsp_pkg::DIST_SHIFT) - 1)
                                                 : PW'(0));
  assign travel_dist = prod_adj[PW-1:wsp_pkg::DIST_SHIFT];
  assign run_x       = RW'(travel_dist);
  assign target_x    = signed'(RW'(cfg.finish_dist));

  assign q_push    = f2_v_r && !q_full;
  assign q_ctl.run = f2_run_r;
  assign q_ctl.fin = f2_run_r && (run_x >= target_x);
  assign q_diff    = f2_diff_r;

endmodule

### rtl/wsp_queue.sv
// wsp_queue: small first-in first-out queue between front and back
// depends on nothing; DEPTH must be a power of two
module wsp_queue #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/wsp_back.sv
// wsp_back: pid state update and drive computation, four pipeline stages
// ending in the output register; depends on wsp_pkg
module wsp_back #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wsp_pkg::wsp_cfg_t                   cfg,
  input  logic                                q_valid,
  input  wsp_pkg::wsp_ctl_t                   q_ctl,
  input  logic signed [COUNT_BITS:0]          q_diff,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_drive_valid,
  output logic signed [wsp_pkg::DRIVE_W-1:0]  out_left_drive,
  output logic signed [wsp_pkg::DRIVE_W-1:0]  out_right_drive,
  output logic                                out_finished
);

  localparam int DW  = COUNT_BITS + 1;
  localparam int SW  = ((DW > wsp_pkg::SUM_W) ? DW : wsp_pkg::SUM_W) + 1;
  localparam int TW  = ((COUNT_BITS + 3 > wsp_pkg::DRIVE_W) ? COUNT_BITS + 3
                                                           : wsp_pkg::DRIVE_W) + 2;
  localparam int PRW = wsp_pkg::DIV_IN_W + wsp_pkg::DIV_K_W;

  localparam logic signed [SW-1:0] SUM_MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SUM_MIN = SW'(-64'sd2147483648);
  localparam logic signed [TW:0]   DRV_MAX = (TW+1)'(64'sd134217727);
  localparam logic signed [TW:0]   DRV_MIN = (TW+1)'(-64'sd134217728);

  // pid state
  logic signed [DW-1:0]             prev_err_r;
  logic signed [wsp_pkg::SUM_W-1:0] sum_r;
  logic [wsp_pkg::PERIOD_W-1:0]     tick_r;

  // pipeline registers
  logic                             b1_v_r, b2_v_r, b3_v_r, o_v_r;
  wsp_pkg::wsp_ctl_t                b1_ctl_r, b2_ctl_r, b3_ctl_r;
  logic signed [wsp_pkg::SUM_W-1:0] b1_sum_r;
  logic signed [DW:0]               b1_p_r;
  logic signed [DW+1:0]             b1_d_r;
  logic [wsp_pkg::IMAG_W-1:0]       b2_qmag_r;
  logic                             b2_neg_r;
  logic signed [TW-1:0]             b2_pd_r, b3_turn_r;
  logic                             o_drive_valid_r, o_fin_r;
  logic signed [wsp_pkg::DRIVE_W-1:0] o_left_r, o_right_r;

  logic                             b1_en, b2_en, b3_en, o_en;
  logic signed [SW-1:0]             sum_ext;
  logic signed [wsp_pkg::SUM_W-1:0] sum_sat;
  logic [wsp_pkg::PERIOD_W:0]       tick_inc;
  logic                             period_hit;
  logic signed [DW+1:0]             triple, triple_adj;
  logic signed [DW:0]               err_step;
  logic [wsp_pkg::SUM_W-1:0]        sum_mag;
  logic [PRW-1:0]                   div_prod;
  logic signed [TW-1:0]             qmag_x;
  logic signed [TW:0]               left_raw, right_raw;

  function automatic logic signed [wsp_pkg::DRIVE_W-1:0] sat_drive(
    input logic signed [TW:0] v
  );
    logic signed [wsp_pkg::DRIVE_W-1:0] r;
    if (v > DRV_MAX) begin
      r = DRV_MAX[wsp_pkg::DRIVE_W-1:0];
    end else if (v < DRV_MIN) begin
      r = DRV_MIN[wsp_pkg::DRIVE_W-1:0];
    end else begin
      r = v[wsp_pkg::DRIVE_W-1:0];
    end
    return r;
  endfunction

  // stage enables, stalling back from the result channel
  assign o_en  = !o_v_r || out_ready;
  assign b3_en = !b3_v_r || o_en;
  assign b2_en = !b2_v_r || b3_en;
  assign b1_en = !b1_v_r || b2_en;
  assign q_pop = q_valid && b1_en;

  // stage 1: saturating integral sum and period counter
  assign sum_ext    = SW'(sum_r) + SW'(q_diff);
  assign tick_inc   = (wsp_pkg::PERIOD_W+1)'(tick_r) + (wsp_pkg::PERIOD_W+1)'(1);
  assign period_hit = (tick_inc >= (wsp_pkg::PERIOD_W+1)'(cfg.integral_period));

  always_comb begin
    if (sum_ext > SUM_MAX) begin
      sum_sat = SUM_MAX[wsp_pkg::SUM_W-1:0];
    end else if (sum_ext < SUM_MIN) begin
      sum_sat = SUM_MIN[wsp_pkg::SUM_W-1:0];
    end else begin
      sum_sat = sum_ext[wsp_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      tick_r     <= '0;
      prev_err_r <= '0;
    end else if (q_pop && q_ctl.run) begin
      if (q_ctl.fin) begin
        sum_r <= sum_sat;
      end else begin
        sum_r      <= period_hit ? '0 : sum_sat;
        tick_r     <= period_hit ? '0 : tick_inc[wsp_pkg::PERIOD_W-1:0];
        prev_err_r <= q_diff;
      end
    end
  end

  // proportional term 3*diff/2 and derivative term 2*(diff - previous)
  assign triple     = (DW+2)'(q_diff) + ((DW+2)'(q_diff) <<< 1);
  assign triple_adj = triple + (DW+2)'(triple[DW+1]);
  assign err_step   = (DW+1)'(q_diff) - (DW+1)'(prev_err_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (b1_en) begin
      b1_v_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_en) begin
      b1_ctl_r <= q_ctl;
      b1_sum_r <= sum_sat;
      b1_p_r   <= triple_adj[DW+1:1];
      b1_d_r   <= err_step <<< 1;
    end
  end

  // stage 2: integral magnitude sum/20 by reciprocal multiply, and the p + d sum
  assign sum_mag  = b1_sum_r[wsp_pkg::SUM_W-1] ? 32'(-b1_sum_r) : 32'(b1_sum_r);
  assign div_prod = PRW'(sum_mag[wsp_pkg::SUM_W-1:2]) * PRW'(wsp_pkg::DIV5_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else if (b2_en) begin
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_en) begin
      b2_ctl_r  <= b1_ctl_r;
      b2_qmag_r <= div_prod[wsp_pkg::DIV_SHIFT +: wsp_pkg::IMAG_W];
      b2_neg_r  <= b1_sum_r[wsp_pkg::SUM_W-1];
      b2_pd_r   <= TW'(b1_p_r) + TW'(b1_d_r);
    end
  end

  // stage 3: turn = p + d +/- integral magnitude
  assign qmag_x = signed'(TW'(b2_qmag_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_v_r <= 1'b0;
    end else if (b3_en) begin
      b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b3_en) begin
      b3_ctl_r  <= b2_ctl_r;
      b3_turn_r <= b2_neg_r ? (b2_pd_r - qmag_x) : (b2_pd_r + qmag_x);
    end
  end

  // stage 4: saturated drives into the output register
  assign left_raw  = (TW+1)'(cfg.base_pwm) + (TW+1)'(b3_turn_r);
  assign right_raw = (TW+1)'(cfg.base_pwm) - (TW+1)'(b3_turn_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_en) begin
      o_v_r <= b3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      o_drive_valid_r <= b3_ctl_r.run && !b3_ctl_r.fin;
      o_fin_r         <= b3_ctl_r.run && b3_ctl_r.fin;
      o_left_r        <= (b3_ctl_r.run && !b3_ctl_r.fin) ? sat_drive(left_raw) : '0;
      o_right_r       <= (b3_ctl_r.run && !b3_ctl_r.fin) ? sat_drive(right_raw) : '0;
    end
  end

  assign out_valid       = o_v_r;
  assign out_drive_valid = o_drive_valid_r;
  assign out_left_drive  = o_left_r;
  assign out_right_drive = o_right_r;
  assign out_finished    = o_fin_r;

endmodule
